[hdl/scmp_pkg.sv]
`default_nettype none
package scmp_pkg;
   localparam int ROWS_DEFAULT = 1024;
   localparam int ROW_W = 10;
   localparam int VAL_W = 64;
   localparam int TOL_W = 63;
   localparam logic [TOL_W-1:0] TOL_RESET = 63'h3CE0000000000000;
   localparam logic [VAL_W-1:0] NEG_DBL_MAX = 64'hFFEFFFFFFFFFFFFF;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ACC   = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ACC,
      ST_READ
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic do_acc;
      logic do_read;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } status_type;

   // ieee less-than on raw bits; nan never compares
   function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
      logic a_nan;
      logic b_nan;
      logic a_zero;
      logic b_zero;
      logic res;
      a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      a_zero = (a[62:0] == 63'd0);
      b_zero = (b[62:0] == 63'd0);
      if (a_nan || b_nan || (a_zero && b_zero)) begin
         res = 1'b0;
      end else if (a[63] != b[63]) begin
         res = a[63];
      end else if (a[63]) begin
         res = a[62:0] > b[62:0];
      end else begin
         res = a[62:0] < b[62:0];
      end
      return res;
   endfunction
endpackage
`default_nettype wire

[hdl/scmp_ctrl.sv]
`default_nettype none
module scmp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_type,
   input  wire scmp_pkg::status_type status,
   output logic                      busy,
   output scmp_pkg::cmd_type         cmd
);
   import scmp_pkg::*;

   state_type state_ff, state_in;

   // reset leaves the controller sweeping the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.capture = start;
            if (start) begin
               case (req_type)
                  REQ_CLEAR: state_in = ST_CLEAR;
                  REQ_ACC:   state_in = ST_ACC;
                  REQ_READ:  state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_ACC: begin
            cmd.do_acc = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            cmd.do_read = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy) else $error("idle but busy");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.do_acc, cmd.do_read})) else $error("cmd clash");
   a_acc_short: assert property (@(posedge clock) disable iff (reset)
      cmd.do_acc |=> !busy) else $error("acc not one cycle");
`endif
endmodule
`default_nettype wire

[hdl/scmp_dp.sv]
`default_nettype none
module scmp_dp #(
   parameter int ROWS = scmp_pkg::ROWS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire scmp_pkg::cmd_type                 cmd,
   output scmp_pkg::status_type                   status,
   input  wire logic                              csr_write,
   input  wire logic [scmp_pkg::TOL_W-1:0]        csr_data,
   input  wire logic [scmp_pkg::ROW_W-1:0]        row_index,
   input  wire logic [scmp_pkg::VAL_W-1:0]        matrix_value,
   input  wire logic [scmp_pkg::VAL_W-1:0]        column_x,
   output logic                                   rsp_valid,
   output logic [scmp_pkg::VAL_W-1:0]             rsp_row_max,
   output logic                                   rsp_row_touched
);
   import scmp_pkg::*;
   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW = $clog2(ROWS + 1);

   logic [VAL_W-1:0] best_mem [ROWS];
   logic             valid_mem [ROWS];
   logic [TOL_W-1:0] tol_ff;
   logic [ROW_W-1:0] row_ff;
   logic [VAL_W-1:0] aval_ff, x_ff, rd_ff, max_ff;
   logic [CW-1:0]    clr_ff;
   logic             in_range, vld_rd, skip, wins, upd, rsp_ff, touch_ff, vld_ff;
   logic             vld_we, vld_wd;
   logic [AW-1:0]    vld_wa;
   logic [VAL_W-1:0] cur;
   logic [AW-1:0]    addr;

   assign in_range = {{(32-ROW_W){1'b0}}, row_ff} < 32'(ROWS);
   assign addr = AW'(row_ff);
   assign status.clear_done = (clr_ff == CW'(ROWS - 1));
   assign upd = cmd.do_acc && in_range && !skip && wins;

   // one valid write port: the clear sweep zeroes, an accepted entry sets
   assign vld_we = cmd.clear_step || upd;
   assign vld_wa = cmd.clear_step ? AW'(clr_ff) : addr;
   assign vld_wd = !cmd.clear_step;

   // registered memory reads at capture, row held until used
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff  <= row_index;
         aval_ff <= matrix_value;
         x_ff    <= column_x;
         rd_ff   <= best_mem[AW'(row_index)];
         vld_ff  <= valid_mem[AW'(row_index)];
      end
      if (upd) begin
         best_mem[addr] <= x_ff;
      end
      if (vld_we) begin
         valid_mem[vld_wa] <= vld_wd;
      end
   end

   assign vld_rd = in_range && vld_ff;
   assign cur = vld_rd ? rd_ff : NEG_DBL_MAX;
   assign skip = fp_lt({1'b0, aval_ff[62:0]}, {1'b0, tol_ff});
   assign wins = fp_lt(cur, x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         clr_ff <= '0;
         rsp_ff <= 1'b0;
      end else begin
         if (csr_write) tol_ff <= csr_data;
         rsp_ff <= cmd.do_read;
         // one valid bit per row cleared per cycle
         if (cmd.clear_step) begin
            clr_ff <= status.clear_done ? '0 : clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_read) begin
         max_ff   <= cur;
         touch_ff <= vld_rd;
      end
   end

   assign rsp_valid = rsp_ff;
   assign rsp_row_max = max_ff;
   assign rsp_row_touched = touch_ff;

`ifndef ASSERT_OFF
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_ff |-> $past(cmd.do_read)) else $error("stray response");
   a_untouched_neg: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff && !touch_ff) |-> (max_ff == NEG_DBL_MAX)) else $error("bad untouched");
   a_clr_range: assert property (@(posedge clock) disable iff (reset)
      clr_ff < CW'(ROWS)) else $error("clear count overrun");
`endif
endmodule
`default_nettype wire

[hdl/sparse_column_max_product_unit.sv]
`default_nettype none
// a request is registered as start is taken in idle; an accumulate writes the row in ACC, and a
// read has READ register rsp_row_max and rsp_valid; no new request is taken until back in idle
// a clear sweeps the row valid bits one per cycle over all ROWS rows with busy high
// reset: synchronous active high; tolerance returns to 8 epsilon (2^-49), then a sweep
// marks all rows untouched with busy high; the receiver cannot stall, rsp_valid is a strobe
module sparse_column_max_product_unit #(
   parameter int ROWS = scmp_pkg::ROWS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_type,
   input  wire logic [scmp_pkg::ROW_W-1:0]   req_row_index,
   input  wire logic [scmp_pkg::VAL_W-1:0]   req_matrix_value,
   input  wire logic [scmp_pkg::VAL_W-1:0]   req_column_x,
   output logic                              rsp_valid,
   output logic [scmp_pkg::VAL_W-1:0]        rsp_row_max,
   output logic                              rsp_row_touched,
   input  wire logic                         csr_write,
   input  wire logic [scmp_pkg::TOL_W-1:0]   csr_data
);
   import scmp_pkg::*;

   cmd_type    cmd;     // controller to datapath
   status_type status;  // datapath to controller

   // controller: decodes the item type, sequences clear sweep
   scmp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // datapath: row store, valid bits, ieee compares
   scmp_dp #(.ROWS(ROWS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_write),
      .csr_data        (csr_data),
      .row_index       (req_row_index),
      .matrix_value    (req_matrix_value),
      .column_x        (req_column_x),
      .rsp_valid       (rsp_valid),
      .rsp_row_max     (rsp_row_max),
      .rsp_row_touched (rsp_row_touched)
   );
endmodule
`default_nettype wire
